// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the hash set block.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Overlapping implication built on the macro above
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication built on the first macro
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// File: rtl/mhis_pkg.sv
// Package for the modulo-hash integer set: sizes, codes and types.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package mhis_pkg;

	localparam int BUCKETS    = 16;
	localparam int WAYS       = 4;
	localparam int KEY_W      = 32;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_W      = 5;
	localparam int CFG_RESET  = 9;
	localparam int REM_W      = CFG_W;
	localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int DIV_STEPS  = 2 * KEY_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int KIDX_W     = $clog2(KEY_W);
	localparam int IN_TDATA_W  = ((ACT_W + KEY_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((1 + STAT_W + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_SEARCH = 2'd1,
		ACT_DELETE = 2'd2
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_EXISTS = 2'd1,
		STAT_FULL   = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_LOOK
	} state_t;

	typedef logic [WAYS-1:0][KEY_W-1:0] key_row_t;

endpackage

`default_nettype wire

// File: rtl/modulo_hash_integer_set.sv
// Each item passes through 64 remainder steps, a row read and a lookup before its result is valid.
// Items are not overlapped; the bit-serial remainder unit takes one dividend bit a cycle.
// A result waits in the output register; input is taken again once the lookup has committed.
// Reset (arst_n low, asynchronous) empties the table at once via per-slot valid flops,
// restores bucket_count to 9 and drops any pending result. Key storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module modulo_hash_integer_set import mhis_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [1:0] action, [33:2] key, rest zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [2:1] status, rest zero
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data   // bucket_count
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [REM_W-1:0]   rem_q, rem_nxt;
	logic [KEY_W-1:0]   key_q;
	logic [ACT_W-1:0]   act_q;
	logic [CFG_W-1:0]   cfg_q;
	logic [REM_W-1:0]   eff_cnt;
	logic               div_bit;
	logic [REM_W:0]     trial;
	logic [BKT_W-1:0]   bucket;

	key_row_t           key_mem_q [BUCKETS];
	key_row_t           row_q;
	logic [WAYS-1:0]    valid_q [BUCKETS];

	logic               m_tvalid_q;
	logic               out_found_q;
	logic [STAT_W-1:0]  out_status_q;

	logic               accept, div_en, rd_en, out_free, commit;
	logic [WAYS-1:0]    vrow;
	logic               hit, has_free;
	logic [WAY_W-1:0]   hit_way, free_way;
	logic               found_d;
	logic [STAT_W-1:0]  status_d;
	logic               do_store, do_clear;
	key_row_t           wr_row;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = OUT_TDATA_W'({out_status_q, out_found_q});
	assign out_free  = !m_tvalid_q || m_tready;
	assign bucket    = BKT_W'(rem_q);

	// Saturate the modulus to the legal range
	always_comb begin
		if (cfg_q == '0) begin
			eff_cnt = REM_W'(1);
		end else if (int'(cfg_q) > BUCKETS) begin
			eff_cnt = REM_W'(BUCKETS);
		end else begin
			eff_cnt = cfg_q;
		end
	end

	// One restoring step: dividend is the key sign-extended to 64 bits, MSB first
	always_comb begin
		if (cnt_q >= CNT_W'(KEY_W)) begin
			div_bit = key_q[KEY_W-1];
		end else begin
			div_bit = key_q[cnt_q[KIDX_W-1:0]];
		end
		trial = {rem_q, div_bit};
		if (trial >= {1'b0, eff_cnt}) begin
			rem_nxt = REM_W'(trial - {1'b0, eff_cnt});
		end else begin
			rem_nxt = REM_W'(trial);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == '0) state_d = S_READ;
			end
			S_READ: state_d = S_LOOK;
			S_LOOK: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		div_en   = 1'b0;
		rd_en    = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_DIV:  div_en   = 1'b1;
			S_READ: rd_en    = 1'b1;
			S_LOOK: commit   = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Bucket lookup: lowest matching way and lowest free way
	always_comb begin
		vrow     = valid_q[bucket];
		hit      = 1'b0;
		hit_way  = '0;
		has_free = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vrow[w] && row_q[w] == key_q) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!vrow[w]) begin
				has_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		found_d  = 1'b0;
		status_d = STAT_DONE;
		do_store = 1'b0;
		do_clear = 1'b0;
		wr_row   = row_q;
		unique case (act_q)
			ACT_INSERT: begin
				if (hit) begin
					found_d  = 1'b1;
					status_d = STAT_EXISTS;
				end else if (has_free) begin
					do_store = 1'b1;
				end else begin
					status_d = STAT_FULL;
				end
			end
			ACT_SEARCH: found_d = hit;
			ACT_DELETE: begin
				found_d  = hit;
				do_clear = hit;
			end
			default: found_d = 1'b0;
		endcase
		wr_row[free_way] = key_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cfg_q      <= CFG_W'(CFG_RESET);
			m_tvalid_q <= 1'b0;
			for (int b = 0; b < BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) cfg_q <= cfg_data;
			if (accept) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (div_en) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (commit && do_store) valid_q[bucket][free_way] <= 1'b1;
			if (commit && do_clear) valid_q[bucket][hit_way]  <= 1'b0;
		end
	end

	// Payload and item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_tdata[ACT_W-1:0];
			key_q <= s_tdata[ACT_W +: KEY_W];
			rem_q <= '0;
		end else if (div_en) begin
			rem_q <= rem_nxt;
		end
		if (commit) begin
			out_found_q  <= found_d;
			out_status_q <= status_d;
		end
	end

	// Key store: one row of WAYS keys per bucket, registered read
	always_ff @(posedge clk) begin
		if (rd_en) row_q <= key_mem_q[bucket];
		if (commit && do_store) key_mem_q[bucket] <= wr_row;
	end

endmodule

`default_nettype wire

// File: rtl/mhis_checker.sv
// Port-level checker for the modulo-hash integer set, bound to the top level.
// Depends on mhis_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mhis_checker import mhis_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// Hold a stalled result
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	// An ignored insert always saw the key
	`ASSERT_IMPL(a_exists_found, m_tvalid && m_tdata[2:1] == STAT_EXISTS, m_tdata[0], "exists without found")
	// A refused insert never saw the key
	`ASSERT_IMPL(a_full_absent, m_tvalid && m_tdata[2:1] == STAT_FULL, !m_tdata[0], "full with found")
	// Busy once an item is taken
	`ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind modulo_hash_integer_set mhis_checker u_mhis_checker (.*);

`default_nettype wire
